// File: rtl/sdsr_pkg.sv
// Shared constants, types and command/status bundles for the dead-stream
// replacement block. No dependencies.
package sdsr_pkg;

    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int SIG_BITS     = 6;
    localparam int DECAY_PERIOD = 100000;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int NUM_SIGS = 1 << SIG_BITS;
    localparam int TICK_W   = $clog2(DECAY_PERIOD + 1);
    localparam int ADDR_W   = 64;
    localparam int MASK_W   = 16;
    localparam int SCNT_W   = 3;
    localparam int THR_W    = 3;

    localparam logic [1:0]        RRPV_MAX  = 2'd3;
    localparam logic [1:0]        RRPV_NEAR = 2'd2;
    localparam logic [1:0]        CTR_MAX   = 2'd3;
    localparam logic [1:0]        CTR_REUSE = 2'd2;
    localparam logic [1:0]        DEAD_MAX  = 2'd3;
    localparam logic [1:0]        DEAD_LIVE = 2'd1;
    localparam logic [SCNT_W-1:0] SCNT_MAX  = 3'd7;
    localparam logic [THR_W-1:0]  THR_RST   = 3'd4;

    // input beat layout
    localparam int SET_LSB  = 0;
    localparam int WAY_LSB  = SET_LSB + SET_W;
    localparam int MASK_LSB = WAY_LSB + WAY_W;
    localparam int PC_LSB   = MASK_LSB + MASK_W;
    localparam int ADR_LSB  = PC_LSB + ADDR_W;
    localparam int S_TDATA_W = ((ADR_LSB + ADDR_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        MODE_VICTIM = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_TICK   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [NUM_WAYS-1:0][1:0]          rrpv;
        logic [NUM_WAYS-1:0][1:0]          dead;
        logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig;
    } t_blk_row;

    typedef struct packed {
        logic [ADDR_W-1:0] prev_addr;
        logic [ADDR_W-1:0] prev_stride;
        logic [SCNT_W-1:0] cnt;
    } t_set_row;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic vict;
        logic u1;
        logic u2;
        logic u3;
        logic tick;
        logic dec_rd;
        logic dec_wr;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       is_hit;
        logic       ptr_last;
        logic       tick_wrap;
        logic       out_full;
    } t_sts;

endpackage

// File: rtl/sdsr_ctrl.sv
// Sequencer for the dead-stream replacement block.
// Depends on sdsr_pkg; drives the datapath through t_cmd.
module sdsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  sdsr_pkg::t_sts i_sts,
    output sdsr_pkg::t_cmd o_cmd
);
    import sdsr_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_VIC, S_U1, S_U2, S_U3, S_TICK, S_DRD, S_DWR, S_DONE
    } t_state;

    t_state r_state;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.clr    = (r_state == S_CLR);
        o_cmd.load   = (r_state == S_IDLE) && s_axis_tvalid;
        o_cmd.rd     = (r_state == S_RD);
        o_cmd.vict   = (r_state == S_VIC);
        o_cmd.u1     = (r_state == S_U1);
        o_cmd.u2     = (r_state == S_U2);
        o_cmd.u3     = (r_state == S_U3);
        o_cmd.tick   = (r_state == S_TICK);
        o_cmd.dec_rd = (r_state == S_DRD);
        o_cmd.dec_wr = (r_state == S_DWR);
        o_cmd.push   = (r_state == S_DONE) && !i_sts.out_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            unique case (r_state)
                S_CLR:  if (i_sts.ptr_last) r_state <= S_IDLE;
                S_IDLE: if (s_axis_tvalid) r_state <= S_RD;
                S_RD: begin
                    unique case (t_mode'(i_sts.mode))
                        MODE_VICTIM: r_state <= S_VIC;
                        MODE_UPDATE: r_state <= S_U1;
                        MODE_TICK:   r_state <= S_TICK;
                        default:     r_state <= S_DONE;
                    endcase
                end
                S_VIC:  r_state <= S_DONE;
                S_U1:   r_state <= S_U2;
                S_U2:   r_state <= i_sts.is_hit ? S_DONE : S_U3;
                S_U3:   r_state <= S_DONE;
                S_TICK: r_state <= i_sts.tick_wrap ? S_DRD : S_DONE;
                S_DRD:  r_state <= S_DWR;
                S_DWR:  r_state <= i_sts.ptr_last ? S_DONE : S_DRD;
                S_DONE: if (!i_sts.out_full) r_state <= S_IDLE;
                default: r_state <= S_CLR;
            endcase
        end
    end

endmodule

// File: rtl/sdsr_dp.sv
// Datapath: block, set and signature memories, stride detector, victim
// selection and output register. Depends on sdsr_pkg; run by sdsr_ctrl.
module sdsr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sdsr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [sdsr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [sdsr_pkg::THR_W-1:0]       i_cfg_wdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sdsr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser,
    input  sdsr_pkg::t_cmd                   i_cmd,
    output sdsr_pkg::t_sts                   o_sts
);
    import sdsr_pkg::*;

    t_blk_row          r_blk_mem [NUM_SETS];
    t_set_row          r_set_mem [NUM_SETS];
    logic [1:0]        r_sig_mem [NUM_SIGS];

    t_blk_row          r_blk_q;
    t_set_row          r_set_q;
    logic [1:0]        r_sig_q;

    logic [1:0]          r_mode;
    logic                r_hit;
    logic [SET_W-1:0]    r_set;
    logic [WAY_W-1:0]    r_way;
    logic [MASK_W-1:0]   r_mask;
    logic [SIG_BITS-1:0] r_sig;
    logic [ADDR_W-1:0]   r_addr;
    logic [SCNT_W-1:0]   r_cnt;
    logic [WAY_W-1:0]    r_vic;
    logic                r_byp;
    logic [SET_W-1:0]    r_ptr;
    logic [TICK_W-1:0]   r_tick;
    logic [THR_W-1:0]    r_thr;
    logic                r_ovalid;
    logic [WAY_W-1:0]    r_ovic;
    logic                r_obyp;

    logic [ADDR_W-1:0]   pc_in;
    logic [ADDR_W-1:0]   hash_full;
    logic                blk_we;
    logic [SET_W-1:0]    blk_waddr;
    logic [SET_W-1:0]    blk_raddr;
    t_blk_row            blk_wdata;
    logic                set_we;
    logic [SET_W-1:0]    set_waddr;
    t_set_row            set_wdata;
    logic                sig_we;
    logic [SIG_BITS-1:0] sig_waddr;
    logic [SIG_BITS-1:0] sig_raddr;
    logic [1:0]          sig_wdata;
    logic                all_valid;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    age_way;
    logic [1:0]          top;
    logic [1:0]          age_add;
    logic [NUM_WAYS-1:0][1:0] aged;
    logic [ADDR_W-1:0]   stride;
    logic [SCNT_W-1:0]   n_cnt;
    logic [SIG_BITS-1:0] old_sig;
    logic                stream;
    logic                reuse;

    assign pc_in     = s_axis_tdata[PC_LSB +: ADDR_W];
    assign hash_full = pc_in ^ (pc_in >> 6) ^ (pc_in >> 12);
    assign old_sig   = r_blk_q.sig[r_way];
    assign stream    = (r_cnt >= r_thr);
    assign reuse     = (r_sig_q >= CTR_REUSE) && (r_blk_q.dead[r_way] <= DEAD_LIVE);

    always_comb begin
        all_valid = &r_mask;
        inv_way   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!r_mask[w]) inv_way = WAY_W'(w);
        end
        top = 2'd0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_blk_q.rrpv[w] > top) top = r_blk_q.rrpv[w];
        end
        age_add = RRPV_MAX - top;
        age_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            aged[w] = r_blk_q.rrpv[w] + age_add;
            if (aged[w] == RRPV_MAX) age_way = WAY_W'(w);
        end
    end

    always_comb begin
        stride = r_addr - r_set_q.prev_addr;
        if ((r_set_q.prev_stride != '0) && (stride == r_set_q.prev_stride)) begin
            n_cnt = (r_set_q.cnt == SCNT_MAX) ? SCNT_MAX : r_set_q.cnt + 1'b1;
        end else begin
            n_cnt = '0;
        end
    end

    always_comb begin
        blk_we    = 1'b0;
        blk_waddr = r_set;
        blk_raddr = i_cmd.dec_rd ? r_ptr : r_set;
        blk_wdata = r_blk_q;
        set_we    = 1'b0;
        set_waddr = r_set;
        set_wdata = '{prev_addr: r_addr, prev_stride: stride, cnt: n_cnt};
        sig_we    = 1'b0;
        sig_waddr = r_sig;
        sig_raddr = r_sig;
        sig_wdata = r_sig_q;
        if (i_cmd.clr) begin
            blk_we    = 1'b1;
            blk_waddr = r_ptr;
            blk_wdata = '0;
            set_we    = 1'b1;
            set_waddr = r_ptr;
            set_wdata = '0;
            sig_we    = 1'b1;
            sig_waddr = r_ptr[SIG_BITS-1:0];
            sig_wdata = '0;
        end
        if (i_cmd.vict && all_valid) begin
            blk_we         = 1'b1;
            blk_wdata.rrpv = aged;
        end
        if (i_cmd.u1) begin
            set_we = 1'b1;
        end
        if (i_cmd.u2) begin
            blk_we = 1'b1;
            if (r_hit) begin
                blk_wdata.rrpv[r_way] = 2'd0;
                blk_wdata.dead[r_way] = 2'd0;
                sig_we    = 1'b1;
                sig_wdata = (r_sig_q == CTR_MAX) ? CTR_MAX : r_sig_q + 1'b1;
            end else begin
                if (stream) begin
                    blk_wdata.rrpv[r_way] = RRPV_MAX;
                    blk_wdata.dead[r_way] = DEAD_MAX;
                end else begin
                    blk_wdata.rrpv[r_way] = reuse ? RRPV_NEAR : RRPV_MAX;
                    blk_wdata.dead[r_way] = 2'd0;
                end
                blk_wdata.sig[r_way] = r_sig;
                sig_raddr = old_sig;
            end
        end
        if (i_cmd.u3) begin
            sig_we    = 1'b1;
            sig_waddr = old_sig;
            sig_wdata = (r_sig_q == 2'd0) ? 2'd0 : r_sig_q - 1'b1;
        end
        if (i_cmd.dec_wr) begin
            blk_we    = 1'b1;
            blk_waddr = r_ptr;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (r_blk_q.dead[w] != 2'd0) blk_wdata.dead[w] = r_blk_q.dead[w] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) r_blk_mem[blk_waddr] <= blk_wdata;
        if (i_cmd.rd || i_cmd.dec_rd) r_blk_q <= r_blk_mem[blk_raddr];
        if (set_we) r_set_mem[set_waddr] <= set_wdata;
        if (i_cmd.rd) r_set_q <= r_set_mem[r_set];
        if (sig_we) r_sig_mem[sig_waddr] <= sig_wdata;
        if (i_cmd.u1 || i_cmd.u2) r_sig_q <= r_sig_mem[sig_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= s_axis_tuser[1:0];
            r_hit  <= s_axis_tuser[2];
            r_set  <= s_axis_tdata[SET_LSB +: SET_W];
            r_way  <= s_axis_tdata[WAY_LSB +: WAY_W];
            r_mask <= s_axis_tdata[MASK_LSB +: MASK_W];
            r_addr <= s_axis_tdata[ADR_LSB +: ADDR_W];
            r_sig  <= hash_full[SIG_BITS-1:0];
            r_vic  <= '0;
            r_byp  <= 1'b0;
        end
        if (i_cmd.vict) r_vic <= all_valid ? age_way : inv_way;
        if (i_cmd.u1) r_cnt <= n_cnt;
        if (i_cmd.u2 && !r_hit) r_byp <= stream;
        if (i_cmd.push) begin
            r_ovic <= r_vic;
            r_obyp <= r_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_tick   <= '0;
            r_thr    <= THR_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr || i_cmd.dec_wr) r_ptr <= r_ptr + 1'b1;
            if (i_cmd.tick) begin
                r_tick <= (r_tick == TICK_W'(DECAY_PERIOD - 1)) ? '0 : r_tick + 1'b1;
            end
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (i_cmd.push) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.is_hit    = r_hit;
    assign o_sts.ptr_last  = (r_ptr == SET_W'(NUM_SETS - 1));
    assign o_sts.tick_wrap = (r_tick == TICK_W'(DECAY_PERIOD - 1));
    assign o_sts.out_full  = r_ovalid && !m_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = M_TDATA_W'(r_ovic);
    assign m_axis_tuser  = r_obyp;

endmodule

// File: rtl/ship_dead_stream_replacement.sv
// Top level of the dead-stream replacement block.
// Depends on sdsr_pkg, sdsr_ctrl and sdsr_dp.
//
//  channel  | direction | content
//  s_axis   | in        | one request beat (victim, update or tick)
//  m_axis   | out       | one result beat per request
//  cfg      | in        | stream_threshold write, no read-back
//
// One memory step each: victim read, choose, done; tick read, tick, done; update
// read, set row, block row, sig decrement if fill, done. Every DECAY_PERIOD-th
// tick sweeps all dead counters. Reset clears every set before the first beat.
// A stalled result holds the sequencer in its last step; one item at a time.
module ship_dead_stream_replacement (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // set_index, way_index, valid_mask, pc, phys_addr, zero pad
    input  logic [sdsr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode, is_hit
    input  logic [sdsr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // victim_way, zero pad
    output logic [sdsr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // stream_bypass
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [sdsr_pkg::THR_W-1:0]       i_cfg_wdata
);
    import sdsr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sdsr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    sdsr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("beat accepted while previous item in flight");

    a_bypass_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bypass flagged on a victim result");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr, cmd.vict, cmd.u2, cmd.dec_wr}))
        else $error("conflicting block row writes");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("beat taken before clearing pass");

endmodule
